@@ src/tssh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tssh_pkg;

   localparam int unsigned MAX_LEN = 32'd65535;
   localparam logic [15:0] COUNT_CAP =
      (MAX_LEN < 32'h0000_ffff) ? MAX_LEN[15:0] : 16'hffff;
   localparam logic [30:0] HASH_MASK = 31'h7fff_ffff;
   localparam logic [31:0] CHECK_MOD = 32'hffff_ffff;
   // a permuted 31-bit value lands on the even bits 2..62 only
   localparam logic [63:0] SUM_MASK = 64'h5555_5555_5555_5554 & ~64'h4000_0000_0000_0000
                                      | 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_string;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic [31:0] checksum;
      logic [15:0] byte_count;
   } rsp_type;

   // output bit 63-i takes input bit 63-i/2 (i even) or (i-1)/2 (i odd)
   function automatic logic [63:0] interleave(input logic [63:0] v);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         if ((i % 2) == 0) begin
            r[63 - i] = v[63 - (i / 2)];
         end else begin
            r[63 - i] = v[(i - 1) / 2];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/token_string_shuffle_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  tssh_pkg::req_type req_data
// rsp       out        rsp_valid / rsp_stall  tssh_pkg::rsp_type rsp_data
//
// One request per cycle unless a held result stalls it; each result is registered.
// The rate is set by one pass through the 64-bit add, 31x31 multiply and
// end-around fold between the request register and the result register.
// Synchronous active-high reset clears the running sum, count and valids.
// A held result stalls requests only while a string-ending request waits behind it.

module token_string_shuffle_hash (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire tssh_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output tssh_pkg::rsp_type  rsp_data
);
   import tssh_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_data_ff, s1_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [63:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;

   logic        req_accept;
   logic        produces;
   logic        advance;
   logic [63:0] c_ext;
   logic [63:0] sum_add;
   logic [30:0] prod;
   logic [63:0] sum_perm;
   logic [32:0] fold1;
   logic [31:0] fold2;
   logic [31:0] checksum;
   logic [15:0] count_inc;

   assign produces   = s1_data_ff.empty_string | s1_data_ff.end_of_string;
   assign advance    = s1_valid_ff & (~produces | ~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   assign c_ext    = {{56{s1_data_ff.char_byte[7]}}, s1_data_ff.char_byte};
   assign sum_add  = sum_ff + c_ext;
   assign prod     = 31'((~sum_add[30:0]) * c_ext[30:0]) & HASH_MASK;
   assign sum_perm = interleave({33'b0, prod});

   assign fold1    = {1'b0, sum_perm[63:32]} + {1'b0, sum_perm[31:0]};
   assign fold2    = fold1[31:0] + {31'b0, fold1[32]};
   assign checksum = (fold2 == CHECK_MOD) ? 32'b0 : fold2;
   assign count_inc = (count_ff == COUNT_CAP) ? count_ff : count_ff + 16'd1;

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_data_in   = req_accept ? req_data : s1_data_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in  = rsp_data_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      if (advance) begin
         priority if (s1_data_ff.empty_string) begin
            sum_in       = '0;
            count_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
         end else if (s1_data_ff.end_of_string) begin
            sum_in       = '0;
            count_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in.checksum   = checksum;
            rsp_data_in.byte_count = count_inc;
         end else begin
            sum_in   = sum_perm;
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      advance && s1_data_ff.empty_string |=> rsp_valid && rsp_data == '0)
      else $error("empty string did not give a zero result");

   a_checksum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.checksum != CHECK_MOD)
      else $error("checksum not reduced");

   a_sum_bits: assert property (@(posedge clock) disable iff (reset)
      (sum_ff & ~SUM_MASK) == 64'b0)
      else $error("running sum has bits outside the permuted positions");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && produces && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a held result");

endmodule

`default_nettype wire
